@@ rtl/apt_pkg.sv @@
// Shared codes for the affine point transform: input modes and register indexes.
package apt_pkg;

  typedef enum logic [1:0] {
    MODE_FWD_POINT  = 2'd0,
    MODE_FWD_VECTOR = 2'd1,
    MODE_INV_POINT  = 2'd2,
    MODE_INV_VECTOR = 2'd3
  } mode_e;

  localparam int unsigned CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_SCALE_X     = 3'd0,
    CFG_SHEAR_Y     = 3'd1,
    CFG_SHEAR_X     = 3'd2,
    CFG_SCALE_Y     = 3'd3,
    CFG_TRANSLATE_X = 3'd4,
    CFG_TRANSLATE_Y = 3'd5
  } cfg_idx_e;

endpackage

@@ rtl/apt_if.sv @@
// Point and result stream interfaces with valid/ready handshake.
interface apt_in_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic                          last_in;

  modport source (output valid, mode, x_in, y_in, last_in, input ready);
  modport sink   (input valid, mode, x_in, y_in, last_in, output ready);
endinterface

interface apt_out_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic                          singular;
  logic                          overflow;
  logic                          last_out;

  modport source (output valid, x_out, y_out, singular, overflow, last_out, input ready);
  modport sink   (input valid, x_out, y_out, singular, overflow, last_out, output ready);
endinterface

@@ rtl/apt_div_step.sv @@
// One restoring division step: shift in one dividend bit, subtract if it fits.
module apt_div_step #(
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 33
) (
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] lo_i,
  input  logic [DW-1:0] ud_i,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] lo_o
);
  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  assign trial = {rem_i, lo_i[QW-1]};
  assign diff  = trial - {1'b0, ud_i};
  assign ge    = ~diff[DW];
  assign rem_o = ge ? diff[DW-1:0] : trial[DW-1:0];
  assign lo_o  = {lo_i[QW-2:0], ge};
endmodule

@@ rtl/affine_point_transform.sv @@
// Top level of the streaming 2D affine point transform.
//
//  channel  dir  payload                                       handshake
//  in_i     in   mode, x_in, y_in, last_in                     valid/ready
//  out_o    out  x_out, y_out, singular, overflow, last_out    valid/ready
//  cfg      in   cfg_idx_i, cfg_data_i                         cfg_we_i
//
// One transaction per cycle sustained while the receiver takes results; the depth is set by the
// COORD_WIDTH + 1 restoring division stages of the inverse path (forward items ride along).
// Each stage holds while its successor is full and stalled, so bubbles collapse and
// input is taken while a result waits at the output register.
// Reset clears valid bits and loads the identity matrix.
module affine_point_transform #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [apt_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]              cfg_data_i,
  apt_in_if.sink                              in_i,
  apt_out_if.source                           out_o
);
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned AW   = CW + 1;
  localparam int unsigned PW   = 2 * CW + 1;
  localparam int unsigned SW   = 2 * CW + F + 3;
  localparam int unsigned DW   = 2 * CW;
  localparam int unsigned NW   = 2 * CW + 2 + F;
  localparam int unsigned QW   = CW + 1;
  localparam int unsigned HW   = NW - QW;
  localparam int unsigned CMPW = (HW > DW) ? HW : DW;
  localparam int unsigned RW   = CW + 3;
  localparam logic [CW-1:0] ONE = CW'(64'd1 << F);
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic              inv;
    logic              sing;
    logic              last;
    logic              ovf;
    logic [CW-1:0]     resx;
    logic [CW-1:0]     resy;
    logic              negx;
    logic              negy;
    logic              bigx;
    logic              bigy;
    logic [DW-1:0]     remx;
    logic [DW-1:0]     remy;
    logic [QW-1:0]     lox;
    logic [QW-1:0]     loy;
    logic [DW-1:0]     ud;
  } div_t;

  // configuration
  logic signed [CW-1:0] sx_q, shy_q, shx_q, sy_q, tx_q, ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q  <= ONE;
      shy_q <= '0;
      shx_q <= '0;
      sy_q  <= ONE;
      tx_q  <= '0;
      ty_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apt_pkg::CFG_SCALE_X:     sx_q  <= cfg_data_i;
        apt_pkg::CFG_SHEAR_Y:     shy_q <= cfg_data_i;
        apt_pkg::CFG_SHEAR_X:     shx_q <= cfg_data_i;
        apt_pkg::CFG_SCALE_Y:     sy_q  <= cfg_data_i;
        apt_pkg::CFG_TRANSLATE_X: tx_q  <= cfg_data_i;
        apt_pkg::CFG_TRANSLATE_Y: ty_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake chain
  logic va_q, vb_q, vc_q, vd_q, vo_q;
  logic [QW:0] vdv_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
  logic [QW:0] rdy_dv;

  always_comb begin
    rdy_o = ~vo_q | out_o.ready;
    rdy_dv[QW] = ~vdv_q[QW] | rdy_o;
    for (int k = QW - 1; k >= 0; k--) begin
      rdy_dv[k] = ~vdv_q[k] | rdy_dv[k+1];
    end
    rdy_d = ~vd_q | rdy_dv[0];
    rdy_c = ~vc_q | rdy_d;
    rdy_b = ~vb_q | rdy_c;
    rdy_a = ~va_q | rdy_b;
  end

  assign in_i.ready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
      vd_q  <= 1'b0;
      vdv_q <= '0;
      vo_q  <= 1'b0;
    end else begin
      if (rdy_a) va_q <= in_i.valid;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
      if (rdy_dv[0]) vdv_q[0] <= vd_q;
      for (int k = 1; k <= QW; k++) begin
        if (rdy_dv[k]) vdv_q[k] <= vdv_q[k-1];
      end
      if (rdy_o) vo_q <= vdv_q[QW];
    end
  end

  // stage A: operands, inverse point removes translation
  logic              a_inv_q, a_tr_q, a_last_q;
  logic signed [AW-1:0] a_q, b_q;
  logic signed [AW-1:0] a_d, b_d;
  logic              in_inv, in_ipt;

  assign in_inv = in_i.mode[1];
  assign in_ipt = (in_i.mode == apt_pkg::MODE_INV_POINT);

  always_comb begin
    a_d = {in_i.x_in[CW-1], in_i.x_in};
    b_d = {in_i.y_in[CW-1], in_i.y_in};
    if (in_ipt) begin
      a_d = $signed({in_i.x_in[CW-1], in_i.x_in}) - $signed({tx_q[CW-1], tx_q});
      b_d = $signed({in_i.y_in[CW-1], in_i.y_in}) - $signed({ty_q[CW-1], ty_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_inv_q  <= in_inv;
      a_tr_q   <= (in_i.mode == apt_pkg::MODE_FWD_POINT);
      a_last_q <= in_i.last_in;
      a_q      <= a_d;
      b_q      <= b_d;
    end
  end

  // stage B: products
  logic              b_inv_q, b_tr_q, b_last_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [DW-1:0] d0_q, d1_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      b_inv_q  <= a_inv_q;
      b_tr_q   <= a_tr_q;
      b_last_q <= a_last_q;
      p0_q     <= PW'(a_q * (a_inv_q ? sy_q : sx_q));
      p1_q     <= PW'(b_q * shx_q);
      p2_q     <= PW'(b_q * (a_inv_q ? sx_q : sy_q));
      p3_q     <= PW'(a_q * shy_q);
      d0_q     <= DW'(sx_q * sy_q);
      d1_q     <= DW'(shy_q * shx_q);
    end
  end

  // stage C: sums and determinant
  logic              c_inv_q, c_last_q;
  logic signed [SW-1:0] sumx_q, sumy_q;
  logic signed [DW:0]   det_q;
  logic signed [SW-1:0] tx_w, ty_w;

  assign tx_w = b_tr_q ? (SW'($signed(tx_q)) <<< F) : '0;
  assign ty_w = b_tr_q ? (SW'($signed(ty_q)) <<< F) : '0;

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      c_inv_q  <= b_inv_q;
      c_last_q <= b_last_q;
      if (b_inv_q) begin
        sumx_q <= SW'(p0_q) - SW'(p1_q);
        sumy_q <= SW'(p2_q) - SW'(p3_q);
      end else begin
        sumx_q <= SW'(p0_q) + SW'(p1_q) + tx_w;
        sumy_q <= SW'(p3_q) + SW'(p2_q) + ty_w;
      end
      det_q <= (DW+1)'(d0_q) - (DW+1)'(d1_q);
    end
  end

  // stage D: forward scaling and saturation, inverse magnitudes
  logic              d_inv_q, d_sing_q, d_last_q, d_ovf_q;
  logic [CW-1:0]     d_resx_q, d_resy_q;
  logic              d_negx_q, d_negy_q;
  logic [NW-1:0]     d_unx_q, d_uny_q;
  logic [DW-1:0]     d_ud_q;
  logic signed [SW-1:0] shx_w, shy_w;
  logic              rngx, rngy;
  logic [SW-1:0]     absx, absy;
  logic [DW:0]       absd;

  assign shx_w = sumx_q >>> F;
  assign shy_w = sumy_q >>> F;
  assign rngx  = (&shx_w[SW-1:CW-1]) | ~(|shx_w[SW-1:CW-1]);
  assign rngy  = (&shy_w[SW-1:CW-1]) | ~(|shy_w[SW-1:CW-1]);
  assign absx  = sumx_q[SW-1] ? SW'(-sumx_q) : SW'(sumx_q);
  assign absy  = sumy_q[SW-1] ? SW'(-sumy_q) : SW'(sumy_q);
  assign absd  = det_q[DW] ? (DW+1)'(-det_q) : (DW+1)'(det_q);

  always_ff @(posedge clk_i) begin
    if (rdy_d) begin
      d_inv_q  <= c_inv_q;
      d_last_q <= c_last_q;
      d_sing_q <= c_inv_q & (det_q == '0);
      d_ovf_q  <= ~(rngx & rngy);
      d_resx_q <= rngx ? shx_w[CW-1:0] : (shx_w[SW-1] ? SAT_MIN : SAT_MAX);
      d_resy_q <= rngy ? shy_w[CW-1:0] : (shy_w[SW-1] ? SAT_MIN : SAT_MAX);
      d_negx_q <= sumx_q[SW-1] ^ det_q[DW];
      d_negy_q <= sumy_q[SW-1] ^ det_q[DW];
      d_unx_q  <= {absx[NW-F-1:0], {F{1'b0}}};
      d_uny_q  <= {absy[NW-F-1:0], {F{1'b0}}};
      d_ud_q   <= absd[DW-1:0];
    end
  end

  // stage E: range check against the divisor, first partial remainder
  div_t dv_q [QW+1];
  div_t dv_step [QW];
  logic [CMPW-1:0] hix, hiy, udx;

  assign hix = CMPW'(d_unx_q[NW-1:QW]);
  assign hiy = CMPW'(d_uny_q[NW-1:QW]);
  assign udx = CMPW'(d_ud_q);

  always_ff @(posedge clk_i) begin
    if (rdy_dv[0]) begin
      dv_q[0].inv  <= d_inv_q;
      dv_q[0].sing <= d_sing_q;
      dv_q[0].last <= d_last_q;
      dv_q[0].ovf  <= d_ovf_q;
      dv_q[0].resx <= d_resx_q;
      dv_q[0].resy <= d_resy_q;
      dv_q[0].negx <= d_negx_q;
      dv_q[0].negy <= d_negy_q;
      dv_q[0].bigx <= (hix >= udx);
      dv_q[0].bigy <= (hiy >= udx);
      dv_q[0].remx <= hix[DW-1:0];
      dv_q[0].remy <= hiy[DW-1:0];
      dv_q[0].lox  <= d_unx_q[QW-1:0];
      dv_q[0].loy  <= d_uny_q[QW-1:0];
      dv_q[0].ud   <= d_ud_q;
    end
  end

  // division stages
  logic [DW-1:0] remx_n [QW];
  logic [DW-1:0] remy_n [QW];
  logic [QW-1:0] lox_n  [QW];
  logic [QW-1:0] loy_n  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_lane
    apt_div_step #(.DW(DW), .QW(QW)) u_x (
      .rem_i (dv_q[k].remx),
      .lo_i  (dv_q[k].lox),
      .ud_i  (dv_q[k].ud),
      .rem_o (remx_n[k]),
      .lo_o  (lox_n[k])
    );
    apt_div_step #(.DW(DW), .QW(QW)) u_y (
      .rem_i (dv_q[k].remy),
      .lo_i  (dv_q[k].loy),
      .ud_i  (dv_q[k].ud),
      .rem_o (remy_n[k]),
      .lo_o  (loy_n[k])
    );

    always_comb begin
      dv_step[k]      = dv_q[k];
      dv_step[k].remx = remx_n[k];
      dv_step[k].remy = remy_n[k];
      dv_step[k].lox  = lox_n[k];
      dv_step[k].loy  = loy_n[k];
    end

    always_ff @(posedge clk_i) begin
      if (rdy_dv[k+1]) begin
        dv_q[k+1] <= dv_step[k];
      end
    end
  end

  // final stage: floor correction, sign, saturation
  div_t fin;
  logic [QW:0]        qux, quy;
  logic signed [RW-1:0] qsx, qsy;
  logic               okx, oky;
  logic [CW-1:0]      fx, fy;

  assign fin = dv_q[QW];
  assign qux = {1'b0, fin.lox} + (QW+1)'(fin.negx & (fin.remx != '0));
  assign quy = {1'b0, fin.loy} + (QW+1)'(fin.negy & (fin.remy != '0));
  assign qsx = fin.negx ? -$signed(RW'(qux)) : $signed(RW'(qux));
  assign qsy = fin.negy ? -$signed(RW'(quy)) : $signed(RW'(quy));
  assign okx = ~fin.bigx & ((&qsx[RW-1:CW-1]) | ~(|qsx[RW-1:CW-1]));
  assign oky = ~fin.bigy & ((&qsy[RW-1:CW-1]) | ~(|qsy[RW-1:CW-1]));
  assign fx  = okx ? qsx[CW-1:0] : (fin.negx ? SAT_MIN : SAT_MAX);
  assign fy  = oky ? qsy[CW-1:0] : (fin.negy ? SAT_MIN : SAT_MAX);

  logic [CW-1:0] ox_q, oy_q;
  logic          osing_q, oovf_q, olast_q;

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      olast_q <= fin.last;
      osing_q <= fin.sing;
      if (fin.sing) begin
        ox_q   <= '0;
        oy_q   <= '0;
        oovf_q <= 1'b0;
      end else if (fin.inv) begin
        ox_q   <= fx;
        oy_q   <= fy;
        oovf_q <= ~(okx & oky);
      end else begin
        ox_q   <= fin.resx;
        oy_q   <= fin.resy;
        oovf_q <= fin.ovf;
      end
    end
  end

  assign out_o.valid    = vo_q;
  assign out_o.x_out    = ox_q;
  assign out_o.y_out    = oy_q;
  assign out_o.singular = osing_q;
  assign out_o.overflow = oovf_q;
  assign out_o.last_out = olast_q;
endmodule

@@ verif/tb_affine_point_transform.sv @@
// Bench for affine_point_transform: directed and random points vs. typed or predicted results.
module tb_affine_point_transform;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 16;
  localparam int unsigned CW   = 32;
  localparam int unsigned DRAIN_CYCLES = CW + 12;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [CW-1:0] x_out;
    logic [CW-1:0] y_out;
    logic          singular;
    logic          overflow;
    logic          last_out;
  } point_res_t;

  typedef struct {
    apt_pkg::mode_e mode;
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic           last;
  } point_t;

  typedef struct {
    int             coef_set;
    apt_pkg::mode_e mode;
    logic [CW-1:0]  x;
    logic [CW-1:0]  y;
    logic           last;
    bit             typed;
    point_res_t     res;
  } vector_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  apt_pkg::cfg_idx_e cfg_idx;
  logic [CW-1:0] cfg_data;

  apt_in_if  #(.COORD_WIDTH(CW)) in_if ();
  apt_out_if #(.COORD_WIDTH(CW)) out_if ();

  affine_point_transform #(.FRAC_BITS(FRAC), .COORD_WIDTH(CW)) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic signed [CW-1:0] coef [6];
  point_res_t expected_q [$];
  int errors;
  int src_idle;
  int snk_idle;
  bit hold_req;
  bit hold_done;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    wide_t r;
    q = n / d;
    r = n - q * d;
    if (r != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(wide_t v, inout logic ovf);
    wide_t lo;
    wide_t hi;
    lo = -(wide_t'(1) <<< (CW - 1));
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    if (v < lo) begin
      ovf = 1'b1;
      return lo[CW-1:0];
    end
    if (v > hi) begin
      ovf = 1'b1;
      return hi[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  function automatic point_res_t transform_point(point_t p);
    point_res_t r;
    wide_t sx, shy, shx, sy, tx, ty, x, y, ax, ay, det, a, b;
    logic ovf;
    sx  = coef[apt_pkg::CFG_SCALE_X];
    shy = coef[apt_pkg::CFG_SHEAR_Y];
    shx = coef[apt_pkg::CFG_SHEAR_X];
    sy  = coef[apt_pkg::CFG_SCALE_Y];
    tx  = coef[apt_pkg::CFG_TRANSLATE_X];
    ty  = coef[apt_pkg::CFG_TRANSLATE_Y];
    x   = $signed(p.x);
    y   = $signed(p.y);
    ovf = 1'b0;
    r.singular = 1'b0;
    r.last_out = p.last;
    r.x_out = '0;
    r.y_out = '0;
    if (p.mode == apt_pkg::MODE_FWD_POINT || p.mode == apt_pkg::MODE_FWD_VECTOR) begin
      ax = x * sx + y * shx;
      ay = x * shy + y * sy;
      if (p.mode == apt_pkg::MODE_FWD_POINT) begin
        ax = ax + (tx <<< FRAC);
        ay = ay + (ty <<< FRAC);
      end
      r.x_out = clamp_coord(ax >>> FRAC, ovf);
      r.y_out = clamp_coord(ay >>> FRAC, ovf);
    end else begin
      det = sx * sy - shy * shx;
      if (det == 0) begin
        r.singular = 1'b1;
      end else begin
        a = (p.mode == apt_pkg::MODE_INV_POINT) ? x - tx : x;
        b = (p.mode == apt_pkg::MODE_INV_POINT) ? y - ty : y;
        r.x_out = clamp_coord(floor_div((a * sy - b * shx) <<< FRAC, det), ovf);
        r.y_out = clamp_coord(floor_div((b * sx - a * shy) <<< FRAC, det), ovf);
      end
    end
    r.overflow = ovf;
    return r;
  endfunction

  // receiver: random ready with one long hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    point_res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction x_out=%h y_out=%h", out_if.x_out, out_if.y_out);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_if.x_out !== e.x_out) begin
          $error("x_out expected %h actual %h", e.x_out, out_if.x_out);
          errors++;
        end
        if (out_if.y_out !== e.y_out) begin
          $error("y_out expected %h actual %h", e.y_out, out_if.y_out);
          errors++;
        end
        if (out_if.singular !== e.singular) begin
          $error("singular expected %b actual %b", e.singular, out_if.singular);
          errors++;
        end
        if (out_if.overflow !== e.overflow) begin
          $error("overflow expected %b actual %b", e.overflow, out_if.overflow);
          errors++;
        end
        if (out_if.last_out !== e.last_out) begin
          $error("last_out expected %b actual %b", e.last_out, out_if.last_out);
          errors++;
        end
      end
    end
  end

  task automatic write_coef(apt_pkg::cfg_idx_e idx, logic [CW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    coef[idx] = val;
  endtask

  task automatic load_matrix(logic [CW-1:0] sx, logic [CW-1:0] shy, logic [CW-1:0] shx,
                             logic [CW-1:0] sy, logic [CW-1:0] tx, logic [CW-1:0] ty);
    write_coef(apt_pkg::CFG_SCALE_X, sx);
    write_coef(apt_pkg::CFG_SHEAR_Y, shy);
    write_coef(apt_pkg::CFG_SHEAR_X, shx);
    write_coef(apt_pkg::CFG_SCALE_Y, sy);
    write_coef(apt_pkg::CFG_TRANSLATE_X, tx);
    write_coef(apt_pkg::CFG_TRANSLATE_Y, ty);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_point(point_t p, bit typed, point_res_t typed_res);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= p.mode;
    in_if.x_in <= p.x;
    in_if.y_in <= p.y;
    in_if.last_in <= p.last;
    do @(posedge clk); while (!in_if.ready);
    expected_q.push_back(typed ? typed_res : transform_point(p));
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return $urandom;
      default: return 32'($signed($urandom_range(1 << 19))) - 32'sd262144;
    endcase
  endfunction

  task automatic load_phase_matrix(int sel);
    logic [CW-1:0] p;
    logic [CW-1:0] q;
    case (sel)
      0: load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      1: load_matrix(32'h0001_0000 + $urandom_range(32767), $urandom_range(65535),
                     32'hffff_0000 + $urandom_range(65535), 32'h0000_8000 + $urandom_range(98303),
                     rand_coord(), rand_coord());
      2: load_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff);
      3: load_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000);
      4: begin
        p = rand_coord();
        q = rand_coord();
        load_matrix(p, p, q, q, rand_coord(), rand_coord());
      end
      default: load_matrix(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff,
                           $urandom, $urandom);
    endcase
  endtask

  vector_row_t vectors [$];
  point_res_t no_res;

  initial begin
    point_t p;
    int set_now;
    errors = 0;
    src_idle = 0;
    snk_idle = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = apt_pkg::CFG_SCALE_X;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.mode = apt_pkg::MODE_FWD_POINT;
    in_if.x_in = '0;
    in_if.y_in = '0;
    in_if.last_in = 1'b0;
    no_res = '{default: '0};
    coef[apt_pkg::CFG_SCALE_X] = 32'h0001_0000;
    coef[apt_pkg::CFG_SHEAR_Y] = '0;
    coef[apt_pkg::CFG_SHEAR_X] = '0;
    coef[apt_pkg::CFG_SCALE_Y] = 32'h0001_0000;
    coef[apt_pkg::CFG_TRANSLATE_X] = '0;
    coef[apt_pkg::CFG_TRANSLATE_Y] = '0;

    // identity after reset
    vectors.push_back('{0, apt_pkg::MODE_FWD_POINT, 32'h0001_0000, 32'h0002_0000, 1'b0, 1'b1,
                        '{32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0, 1'b0}});
    vectors.push_back('{0, apt_pkg::MODE_FWD_VECTOR, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1,
                        '{32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0, 1'b1}});
    vectors.push_back('{0, apt_pkg::MODE_INV_POINT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1,
                        '{32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0}});
    vectors.push_back('{0, apt_pkg::MODE_INV_VECTOR, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b1,
                        '{32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b0, 1'b1}});
    vectors.push_back('{0, apt_pkg::MODE_FWD_POINT, 32'h0000_0001, 32'hffff_ffff, 1'b0, 1'b0,
                        no_res});
    // all-zero matrix: singular in the inverse modes
    vectors.push_back('{1, apt_pkg::MODE_INV_POINT, 32'h1234_5678, 32'h8765_4321, 1'b1, 1'b1,
                        '{32'h0, 32'h0, 1'b1, 1'b0, 1'b1}});
    vectors.push_back('{1, apt_pkg::MODE_INV_VECTOR, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1,
                        '{32'h0, 32'h0, 1'b1, 1'b0, 1'b0}});
    vectors.push_back('{1, apt_pkg::MODE_FWD_POINT, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0,
                        no_res});
    // largest diagonal: saturation
    vectors.push_back('{2, apt_pkg::MODE_FWD_VECTOR, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1,
                        '{32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1, 1'b1}});
    vectors.push_back('{2, apt_pkg::MODE_FWD_POINT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0,
                        no_res});
    vectors.push_back('{2, apt_pkg::MODE_INV_POINT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0,
                        no_res});
    vectors.push_back('{2, apt_pkg::MODE_INV_VECTOR, 32'h0000_0001, 32'hffff_ffff, 1'b1, 1'b0,
                        no_res});
    // general matrix: rounding in all modes
    vectors.push_back('{3, apt_pkg::MODE_FWD_POINT, 32'hffff_8001, 32'h0003_4567, 1'b0, 1'b0,
                        no_res});
    vectors.push_back('{3, apt_pkg::MODE_FWD_VECTOR, 32'h0000_0003, 32'hffff_fffd, 1'b0, 1'b0,
                        no_res});
    vectors.push_back('{3, apt_pkg::MODE_INV_POINT, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0,
                        no_res});
    vectors.push_back('{3, apt_pkg::MODE_INV_VECTOR, 32'h7fff_ffff, 32'h0000_0007, 1'b0, 1'b0,
                        no_res});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_now = 0;
    foreach (vectors[i]) begin
      if (vectors[i].coef_set != set_now) begin
        in_if.valid <= 1'b0;
        wait_idle();
        set_now = vectors[i].coef_set;
        case (set_now)
          1: load_matrix('0, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
          2: load_matrix(32'h7fff_ffff, '0, '0, 32'h7fff_ffff, '0, '0);
          default: load_matrix(32'h0001_8000, 32'hffff_c000, 32'h0000_5555, 32'h0000_c000,
                               32'h0012_3456, 32'hfedc_ba98);
        endcase
      end
      p = '{vectors[i].mode, vectors[i].x, vectors[i].y, vectors[i].last};
      send_point(p, vectors[i].typed, vectors[i].res);
    end
    in_if.valid <= 1'b0;

    for (int prof = 0; prof < 3; prof++) begin
      src_idle = (prof == 0) ? 38 : (prof == 1) ? 50 : 0;
      snk_idle = (prof == 0) ? 50 : (prof == 1) ? 38 : 0;
      for (int sel = 0; sel < 6; sel++) begin
        wait_idle();
        load_phase_matrix(sel);
        if (prof == 2 && sel == 0) hold_req = 1'b1;
        for (int n = 0; n < 70; n++) begin
          p.mode = apt_pkg::mode_e'($urandom_range(3));
          p.x = rand_coord();
          p.y = rand_coord();
          p.last = $urandom_range(1);
          send_point(p, 1'b0, no_res);
        end
        in_if.valid <= 1'b0;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ affine_point_transform.f @@
rtl/apt_pkg.sv
rtl/apt_if.sv
rtl/apt_div_step.sv
rtl/affine_point_transform.sv
verif/tb_affine_point_transform.sv
